### rtl/dtts_pkg.sv
`default_nettype none
// ============================================================================
// dtts_pkg
// Shared types and constants for the timestamp text to seconds converter.
// ============================================================================
package dtts_pkg;

    // Character positions of the fixed record layout
    localparam int unsigned RECORD_LEN   = 22;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned MERIDIEM_POS = 20;

    // Field widths
    localparam int unsigned SMALL_W  = 7;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned HMS_W    = 19;
    localparam int unsigned DAYS_W   = 24;
    localparam int unsigned SEC_W    = 39;

    // Calendar constants
    localparam int unsigned BASE_YEAR      = 1990;
    localparam int unsigned LEAPS_TO_BASE  = 482;   // leap years among 1..1989
    localparam int unsigned RECIP_100      = 5243;  // floor(n/100) = (n*5243) >> 19
    localparam int unsigned RECIP_SHIFT    = 19;

    // Depth of the record queue between front and back
    localparam int unsigned RQ_DEPTH = 2;
    localparam int unsigned RQ_PTR_W = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
    localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // Days before the first of each month, indexed by completed months
    localparam logic [8:0] DAYS_BEFORE_MONTH [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    typedef enum logic [1:0] {
        MER_NONE = 2'd0,
        MER_AM   = 2'd1,
        MER_PM   = 2'd2
    } meridiem_t;

    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_MONTH,
        FLD_DAY,
        FLD_YEAR,
        FLD_HOUR,
        FLD_MINUTE,
        FLD_SECOND
    } field_t;

    typedef enum logic [1:0] {
        REC_OK,
        REC_EMPTY,
        REC_BAD
    } rec_kind_t;

    // One parsed record, hour already adjusted for AM/PM
    typedef struct packed {
        rec_kind_t            kind;
        logic [YEAR_W-1:0]    year;
        logic [SMALL_W-1:0]   month;
        logic [SMALL_W-1:0]   day;
        logic [SMALL_W-1:0]   hour;
        logic [SMALL_W-1:0]   minute;
        logic [SMALL_W-1:0]   second;
    } rec_t;

endpackage
`default_nettype wire

### rtl/dtts_front.sv
`default_nettype none
// ============================================================================
// dtts_front
// Character parser: tracks the position, gathers the decimal fields, notes
// the AM/PM letter and emits one parsed record on the last character.
// ============================================================================
module dtts_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          char_code,
    input  wire logic                last_char,
    input  wire logic                accept,
    output dtts_pkg::rec_t           rec,
    output logic                     rec_push
);
    import dtts_pkg::*;

    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [SMALL_W-1:0] month_reg,  month_next;
    logic [SMALL_W-1:0] day_reg,    day_next;
    logic [YEAR_W-1:0]  year_reg,   year_next;
    logic [SMALL_W-1:0] hour_reg,   hour_next;
    logic [SMALL_W-1:0] minute_reg, minute_next;
    logic [SMALL_W-1:0] second_reg, second_next;
    meridiem_t          mer_reg,    mer_next;
    logic               empty_reg,  empty_next;
    logic               err_reg,    err_next;

    field_t             fld;
    logic               is_digit;
    logic [3:0]         digit;
    logic [SMALL_W-1:0] hour_adj;

    function automatic logic [SMALL_W-1:0] acc7(input logic [SMALL_W-1:0] v,
                                                 input logic [3:0] d);
        logic [SMALL_W+3:0] t;
        t = (SMALL_W+4)'(v) * (SMALL_W+4)'(10) + (SMALL_W+4)'(d);
        return t[SMALL_W-1:0];
    endfunction

    function automatic logic [YEAR_W-1:0] acc14(input logic [YEAR_W-1:0] v,
                                                 input logic [3:0] d);
        logic [YEAR_W+3:0] t;
        t = (YEAR_W+4)'(v) * (YEAR_W+4)'(10) + (YEAR_W+4)'(d);
        return t[YEAR_W-1:0];
    endfunction

    // Classify the current position
    always_comb
    begin
        unique case (pos_reg) inside
            5'd0, 5'd1:               fld = FLD_MONTH;
            5'd3, 5'd4:               fld = FLD_DAY;
            5'd6, 5'd7, 5'd8, 5'd9:   fld = FLD_YEAR;
            5'd11, 5'd12:             fld = FLD_HOUR;
            5'd14, 5'd15:             fld = FLD_MINUTE;
            5'd17, 5'd18:             fld = FLD_SECOND;
            default:                  fld = FLD_NONE;
        endcase
    end

    assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
    assign digit    = char_code[3:0];

    // Gather fields and flags for the current character
    always_comb
    begin
        month_next  = month_reg;
        day_next    = day_reg;
        year_next   = year_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        mer_next    = mer_reg;
        empty_next  = empty_reg;
        err_next    = err_reg;

        if ((pos_reg == '0) && (char_code == 8'h00))
        begin
            empty_next = 1'b1;
        end

        if (fld != FLD_NONE && !is_digit)
        begin
            err_next = 1'b1;
        end

        if (is_digit)
        begin
            case (fld)
                FLD_MONTH:  month_next  = acc7(month_reg, digit);
                FLD_DAY:    day_next    = acc7(day_reg, digit);
                FLD_YEAR:   year_next   = acc14(year_reg, digit);
                FLD_HOUR:   hour_next   = acc7(hour_reg, digit);
                FLD_MINUTE: minute_next = acc7(minute_reg, digit);
                FLD_SECOND: second_next = acc7(second_reg, digit);
                default:    ;
            endcase
        end

        if (pos_reg == POS_W'(MERIDIEM_POS))
        begin
            if (char_code == 8'h50 || char_code == 8'h70)
            begin
                mer_next = MER_PM;
            end
            else if (char_code == 8'h41 || char_code == 8'h61)
            begin
                mer_next = MER_AM;
            end
            else
            begin
                mer_next = MER_NONE;
            end
        end

        pos_next = (pos_reg < POS_W'(RECORD_LEN)) ? pos_reg + 1'b1 : pos_reg;
    end

    // Apply the 12-hour clock rule
    always_comb
    begin
        hour_adj = hour_next;
        if (mer_next == MER_PM && hour_next != 7'd12)
        begin
            hour_adj = hour_next + 7'd12;
        end
        else if (mer_next == MER_AM && hour_next == 7'd12)
        begin
            hour_adj = '0;
        end
    end

    // Build the record handed to the queue
    always_comb
    begin
        rec_push   = accept && last_char;
        rec.year   = year_next;
        rec.month  = month_next;
        rec.day    = day_next;
        rec.hour   = hour_adj;
        rec.minute = minute_next;
        rec.second = second_next;
        if (empty_next)
        begin
            rec.kind = REC_EMPTY;
        end
        else if (err_next || pos_next < POS_W'(RECORD_LEN))
        begin
            rec.kind = REC_BAD;
        end
        else
        begin
            rec.kind = REC_OK;
        end
    end

    // Advance on each accepted character, clear after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            year_reg   <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            mer_reg    <= MER_NONE;
            empty_reg  <= 1'b0;
            err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                pos_reg    <= '0;
                month_reg  <= '0;
                day_reg    <= '0;
                year_reg   <= '0;
                hour_reg   <= '0;
                minute_reg <= '0;
                second_reg <= '0;
                mer_reg    <= MER_NONE;
                empty_reg  <= 1'b0;
                err_reg    <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                year_reg   <= year_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
                mer_reg    <= mer_next;
                empty_reg  <= empty_next;
                err_reg    <= err_next;
            end
        end
    end

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(RECORD_LEN))
        else $error("character position ran past the record length");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |=> (pos_reg == '0) && !err_reg && !empty_reg)
        else $error("parser state not cleared after the last character");

endmodule
`default_nettype wire

### rtl/dtts_rqueue.sv
`default_nettype none
// ============================================================================
// dtts_rqueue
// Short record queue that decouples the parser from the date arithmetic.
// ============================================================================
module dtts_rqueue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  dtts_pkg::rec_t      wr_rec,
    output logic                full,
    output logic                rd_valid,
    input  wire logic           rd_en,
    output dtts_pkg::rec_t      rd_rec
);
    import dtts_pkg::*;

    rec_t                 mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]  cnt_reg,    cnt_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full     = (cnt_reg == RQ_CNT_W'(RQ_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_rec   = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + RQ_CNT_W'(do_wr) - RQ_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming record
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("record dropped: queue full on write");

endmodule
`default_nettype wire

### rtl/dtts_back.sv
`default_nettype none
// ============================================================================
// dtts_back
// Three-stage date arithmetic: year and month terms, day count, then
// seconds. The last stage doubles as the result register.
// ============================================================================
module dtts_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  dtts_pkg::rec_t                in_rec,
    output logic                          in_ready,
    output logic                          out_valid,
    input  wire logic                     out_pop,
    output logic signed [dtts_pkg::SEC_W-1:0] out_seconds,
    output logic                          out_bad
);
    import dtts_pkg::*;

    // Stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // Stage 1 values
    logic [YEAR_W-1:0]  ym1;
    logic [26:0]        prod_m1;
    logic [26:0]        prod_y;
    logic [3:0]         done_months;
    logic [HMS_W-1:0]   hms_s1;

    rec_kind_t          kind1_reg;
    logic               after1_reg;
    logic [YEAR_W-1:0]  yoff1_reg;
    logic [YEAR_W-3:0]  ym1q4_reg;
    logic [6:0]         qm1_reg;
    logic [6:0]         qy_reg;
    logic [YEAR_W-1:0]  year1_reg;
    logic [8:0]         mdays1_reg;
    logic               pastfeb1_reg;
    logic [SMALL_W-1:0] day1_reg;
    logic [HMS_W-1:0]   hms1_reg;

    // Stage 2 values
    logic [YEAR_W-1:0]  leaps;
    logic [21:0]        days_year;
    logic               rem0;
    logic               leap;
    logic [DAYS_W-1:0]  days_s2;

    rec_kind_t          kind2_reg;
    logic signed [DAYS_W-1:0] days2_reg;
    logic [HMS_W-1:0]   hms2_reg;

    // Stage 3 values
    logic signed [41:0] days_ext;
    logic signed [41:0] secs_full;
    logic signed [SEC_W-1:0] sec3_reg;
    logic               bad3_reg;

    assign rdy3     = !v3_reg || out_pop;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: reciprocal quotients by 100, month term, time of day
    always_comb
    begin
        ym1     = in_rec.year - 1'b1;
        prod_m1 = 27'(ym1) * 27'(RECIP_100);
        prod_y  = 27'(in_rec.year) * 27'(RECIP_100);
        if (in_rec.month <= 7'd1)
        begin
            done_months = 4'd0;
        end
        else if (in_rec.month >= 7'd13)
        begin
            done_months = 4'd12;
        end
        else
        begin
            done_months = 4'(in_rec.month - 7'd1);
        end
        hms_s1 = HMS_W'(in_rec.hour) * HMS_W'(3600)
               + HMS_W'(in_rec.minute) * HMS_W'(60)
               + HMS_W'(in_rec.second);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            kind1_reg    <= in_rec.kind;
            after1_reg   <= (in_rec.year > YEAR_W'(BASE_YEAR));
            yoff1_reg    <= in_rec.year - YEAR_W'(BASE_YEAR);
            ym1q4_reg    <= ym1[YEAR_W-1:2];
            qm1_reg      <= prod_m1[RECIP_SHIFT+6:RECIP_SHIFT];
            qy_reg       <= prod_y[RECIP_SHIFT+6:RECIP_SHIFT];
            year1_reg    <= in_rec.year;
            mdays1_reg   <= DAYS_BEFORE_MONTH[done_months];
            pastfeb1_reg <= (done_months >= 4'd2);
            day1_reg     <= in_rec.day;
            hms1_reg     <= hms_s1;
        end
    end

    // Stage 2: Gregorian leap terms and the day count
    always_comb
    begin
        leaps = YEAR_W'(ym1q4_reg) - YEAR_W'(qm1_reg) + YEAR_W'(qm1_reg[6:2])
              - YEAR_W'(LEAPS_TO_BASE);
        days_year = after1_reg ? (22'(yoff1_reg) * 22'd365 + 22'(leaps)) : '0;
        rem0 = (year1_reg == YEAR_W'(qy_reg) * YEAR_W'(100));
        leap = rem0 ? (qy_reg[1:0] == 2'b00) : (year1_reg[1:0] == 2'b00);
        days_s2 = DAYS_W'(days_year) + DAYS_W'(mdays1_reg)
                + DAYS_W'(pastfeb1_reg && leap) + DAYS_W'(day1_reg) - DAYS_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            kind2_reg <= kind1_reg;
            days2_reg <= days_s2;
            hms2_reg  <= hms1_reg;
        end
    end

    // Stage 3: scale days to seconds, zero bad or empty records
    always_comb
    begin
        days_ext  = 42'(days2_reg);
        secs_full = days_ext * 42'sd86400 + $signed(42'(hms2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            sec3_reg <= (kind2_reg == REC_OK) ? secs_full[SEC_W-1:0] : '0;
            bad3_reg <= (kind2_reg == REC_BAD);
        end
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign out_valid   = v3_reg;
    assign out_seconds = sec3_reg;
    assign out_bad     = bad3_reg;

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && bad3_reg) |-> (sec3_reg == '0))
        else $error("bad record carries a nonzero time");

    a_stall_holds_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy2) |=> v2_reg && $stable(days2_reg))
        else $error("stalled day count lost or changed");

endmodule
`default_nettype wire

### rtl/datetime_text_to_seconds_core.sv
`default_nettype none
// ============================================================================
// datetime_text_to_seconds_core
// Converts "MM/DD/YYYY hh:mm:ss AM" text into seconds since 1990-01-01.
// ============================================================================
// Characters are taken one per cycle whenever full is low; full rises only
// when the two-entry record queue is occupied and the arithmetic pipeline
// cannot drain it. A result for a record reaches the result ports through
// the queue write and then three arithmetic stages, the last of which is
// the result register, and results keep flowing at up to one per cycle
// while pop is held, even for one-character records. Up to five records
// can be held while the result side is not popped. A record whose first
// character is NUL gives 0 with bad_format low; a non-digit in a digit
// position or a record shorter than 22 characters gives 0 with bad_format
// high; characters past position 21 are ignored.
module datetime_text_to_seconds_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [7:0]                         char_code,
    input  wire logic                               last_char,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [dtts_pkg::SEC_W-1:0]       seconds_since_base,
    output logic                                    bad_format
);
    import dtts_pkg::*;

    rec_t   front_rec;
    logic   front_push;
    logic   q_full;
    logic   q_valid;
    rec_t   q_rec;
    logic   back_ready;
    logic   back_valid;
    logic   accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    dtts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .last_char (last_char),
        .accept    (accept),
        .rec       (front_rec),
        .rec_push  (front_push)
    );

    dtts_rqueue u_rqueue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_rec   (front_rec),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (back_ready),
        .rd_rec   (q_rec)
    );

    dtts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_rec      (q_rec),
        .in_ready    (back_ready),
        .out_valid   (back_valid),
        .out_pop     (pop),
        .out_seconds (seconds_since_base),
        .out_bad     (bad_format)
    );

    assign empty = !back_valid;

endmodule
`default_nettype wire

### sim/tb_datetime_text_to_seconds_core.sv
// ----------------------------------------------------------------------------
// tb_datetime_text_to_seconds_core
// Self-checking bench for the timestamp text to seconds converter. Records of
// "MM/DD/YYYY hh:mm:ss AM" text are pushed one character per item, directed
// corner records first and then a random mix of well-formed, broken, empty
// and noise records. A scoreboard predicts each record's seconds count and
// flag and compares them with every popped result. Both sides pause at random.
// ----------------------------------------------------------------------------

typedef logic [7:0] char_q_t[$];

typedef struct {
    logic [dtts_pkg::SEC_W-1:0] secs;
    logic                       bad;
} stamp_result_t;

localparam logic [7:0] CH_NUL  = 8'h00;
localparam logic [7:0] CH_ZERO = 8'h30;
localparam logic [7:0] CH_NINE = 8'h39;

localparam longint BASE_Y = longint'(dtts_pkg::BASE_YEAR);

// Days before the first of each month, indexed by completed months
localparam int MONTH_START [13] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
};

class stamp_scoreboard;

    // Record being gathered
    logic [dtts_pkg::POS_W-1:0]   pos;
    logic [dtts_pkg::SMALL_W-1:0] month;
    logic [dtts_pkg::SMALL_W-1:0] day;
    logic [dtts_pkg::YEAR_W-1:0]  year;
    logic [dtts_pkg::SMALL_W-1:0] hour;
    logic [dtts_pkg::SMALL_W-1:0] minute;
    logic [dtts_pkg::SMALL_W-1:0] second;
    dtts_pkg::meridiem_t          mark;
    logic                         empty_rec;
    logic                         fmt_err;

    stamp_result_t pending[$];
    int            mismatches;
    int            results_seen;
    int            records_seen;
    int            records_bad;
    int            records_empty;

    function new();
        pos       = '0;
        month     = '0;
        day       = '0;
        year      = '0;
        hour      = '0;
        minute    = '0;
        second    = '0;
        mark      = dtts_pkg::MER_NONE;
        empty_rec = 1'b0;
        fmt_err   = 1'b0;
    endfunction

    function longint leaps_upto(longint n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function bit is_leap(longint y);
        if (y % 400 == 0) return 1'b1;
        if (y % 100 == 0) return 1'b0;
        return (y % 4) == 0;
    endfunction

    function longint stamp_seconds();
        longint yr;
        longint hr;
        longint days;
        int     done;
        yr   = longint'(year);
        hr   = longint'(hour);
        days = 0;
        if (yr > BASE_Y)
            days = 365 * (yr - BASE_Y) + leaps_upto(yr - 1) - leaps_upto(BASE_Y - 1);
        done = int'(month) - 1;
        if (done < 0) done = 0;
        if (done > 12) done = 12;
        days += MONTH_START[done];
        if (done >= 2 && is_leap(yr)) days += 1;
        days += longint'(day) - 1;
        if (mark == dtts_pkg::MER_PM && hr != 12) hr += 12;
        else if (mark == dtts_pkg::MER_AM && hr == 12) hr = 0;
        return days * 86400 + hr * 3600 + longint'(minute) * 60 + longint'(second);
    endfunction

    // Note one accepted character; queue a result on the last one
    function void note_char(logic [7:0] c, logic last);
        logic          dig;
        logic [3:0]    d;
        stamp_result_t r;
        longint        total;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d   = dig ? 4'(c - CH_ZERO) : 4'd0;
        if (pos == 0 && c == CH_NUL) empty_rec = 1'b1;
        case (pos)
            0, 1:
                if (dig) month = (dtts_pkg::SMALL_W)'(month * 10 + d);
                else fmt_err = 1'b1;
            3, 4:
                if (dig) day = (dtts_pkg::SMALL_W)'(day * 10 + d);
                else fmt_err = 1'b1;
            6, 7, 8, 9:
                if (dig) year = (dtts_pkg::YEAR_W)'(year * 10 + d);
                else fmt_err = 1'b1;
            11, 12:
                if (dig) hour = (dtts_pkg::SMALL_W)'(hour * 10 + d);
                else fmt_err = 1'b1;
            14, 15:
                if (dig) minute = (dtts_pkg::SMALL_W)'(minute * 10 + d);
                else fmt_err = 1'b1;
            17, 18:
                if (dig) second = (dtts_pkg::SMALL_W)'(second * 10 + d);
                else fmt_err = 1'b1;
            default: ;
        endcase
        if (pos == dtts_pkg::MERIDIEM_POS) begin
            case (c)
                "P", "p": mark = dtts_pkg::MER_PM;
                "A", "a": mark = dtts_pkg::MER_AM;
                default:  mark = dtts_pkg::MER_NONE;
            endcase
        end
        if (pos < dtts_pkg::RECORD_LEN) pos = pos + 1'b1;

        if (!last) return;

        // Close the record
        records_seen++;
        if (empty_rec) begin
            r.secs = '0;
            r.bad  = 1'b0;
            records_empty++;
        end else if (fmt_err || pos < dtts_pkg::RECORD_LEN) begin
            r.secs = '0;
            r.bad  = 1'b1;
            records_bad++;
        end else begin
            total  = stamp_seconds();
            r.secs = total[dtts_pkg::SEC_W-1:0];
            r.bad  = 1'b0;
        end
        pending.push_back(r);
        pos       = '0;
        month     = '0;
        day       = '0;
        year      = '0;
        hour      = '0;
        minute    = '0;
        second    = '0;
        mark      = dtts_pkg::MER_NONE;
        empty_rec = 1'b0;
        fmt_err   = 1'b0;
    endfunction

    // Compare one popped result with the oldest prediction
    function void check_result(logic [dtts_pkg::SEC_W-1:0] secs, logic bad);
        stamp_result_t want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result: seconds %0d bad %0b", $signed(secs), bad);
            return;
        end
        want = pending.pop_front();
        results_seen++;
        if (secs !== want.secs || bad !== want.bad) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on result %0d: expected seconds %0d bad %0b, got %0d bad %0b",
                         results_seen, $signed(want.secs), want.bad, $signed(secs), bad);
        end
    endfunction

endclass

module tb_datetime_text_to_seconds_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_CHARS = 1080;
    localparam int CALM_CHARS   = 200;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 5000;
    localparam int TAIL_CYCLES  = 12;

    localparam int DIGIT_POS [14] = '{0, 1, 3, 4, 6, 7, 8, 9, 11, 12, 14, 15, 17, 18};

    logic                         clk;
    logic                         rst_n;
    logic                         push;
    logic                         full;
    logic [7:0]                   char_code;
    logic                         last_char;
    logic                         empty;
    logic                         pop;
    logic [dtts_pkg::SEC_W-1:0]   seconds_since_base;
    logic                         bad_format;

    stamp_scoreboard sb = new();
    bit              calm = 1'b0;
    int              chars_sent = 0;
    int              cycles = 0;

    datetime_text_to_seconds_core u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .char_code          (char_code),
        .last_char          (last_char),
        .empty              (empty),
        .pop                (pop),
        .seconds_since_base (seconds_since_base),
        .bad_format         (bad_format)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Stop a run that hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycles, sb.pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic char_q_t text_chars(string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic char_q_t stamp_chars(int mon, int dy, int yr, int hr, int mn, int sc,
                                            logic [7:0] mer);
        char_q_t q;
        q     = text_chars($sformatf("%02d/%02d/%04d %02d:%02d:%02d AM",
                                     mon, dy, yr, hr, mn, sc));
        q[20] = mer;
        return q;
    endfunction

    // Mostly a calendar-like value, sometimes anything that fits the digits
    function automatic int pick_field(int lo, int hi, int any_hi);
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, any_hi);
        return $urandom_range(lo, hi);
    endfunction

    function automatic logic [7:0] pick_non_digit();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b >= CH_ZERO && b <= CH_NINE);
        return b;
    endfunction

    function automatic char_q_t random_stamp();
        char_q_t    q;
        logic [7:0] mer;
        int         yr;
        int         n;
        case ($urandom_range(0, 9))
            0, 1, 2: mer = "A";
            3, 4, 5: mer = "P";
            6:       mer = "a";
            7:       mer = "p";
            default: mer = 8'($urandom_range(0, 255));
        endcase
        yr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999) : $urandom_range(1980, 2110);
        q  = stamp_chars(pick_field(1, 12, 99), pick_field(1, 31, 99), yr,
                         pick_field(1, 12, 99), pick_field(0, 59, 99), pick_field(0, 59, 99),
                         mer);
        // Scramble an unchecked separator or the trailing M now and then
        if ($urandom_range(0, 6) == 0) begin
            case ($urandom_range(0, 6))
                0: q[2]  = 8'($urandom_range(0, 255));
                1: q[5]  = 8'($urandom_range(0, 255));
                2: q[10] = 8'($urandom_range(0, 255));
                3: q[13] = 8'($urandom_range(0, 255));
                4: q[16] = 8'($urandom_range(0, 255));
                5: q[19] = 8'($urandom_range(0, 255));
                default: q[21] = 8'($urandom_range(0, 255));
            endcase
        end
        // Trail extra characters past the record end
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) q.push_back(8'($urandom_range(0, 255)));
        end
        return q;
    endfunction

    // Push one record, last_char on its final character
    task automatic send_record(input char_q_t chars);
        int gap;
        for (int i = 0; i < chars.size(); i++) begin
            // Hold off the sender for a burst
            if (!calm && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 14);
                repeat (gap) begin
                    @(negedge clk);
                    push <= 1'b0;
                end
            end
            @(negedge clk);
            push      <= 1'b1;
            char_code <= chars[i];
            last_char <= (i == chars.size() - 1);
            do @(posedge clk); while (full);
            sb.note_char(chars[i], i == chars.size() - 1);
            chars_sent++;
        end
    endtask

    // Pop results with random stall bursts and check each one
    initial
    begin : drain_results
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                stall = $urandom_range(1, 14) - 1;
            end else begin
                pop <= 1'b1;
            end
            @(posedge clk);
            if (pop && !empty) sb.check_result(seconds_since_base, bad_format);
        end
    end

    initial
    begin : stimulus
        char_q_t q;
        int      start_chars;
        int      kind;
        int      cut;
        int      drain;
        int      n;

        push      = 1'b0;
        pop       = 1'b0;
        char_code = 8'h00;
        last_char = 1'b0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed records: calendar edges, meridiem forms, bad and empty records
        send_record(text_chars("01/01/1990 12:00:00 AM"));
        send_record(text_chars("12/31/9999 11:59:59 PM"));
        send_record(text_chars("02/29/2000 11:59:59 pm"));
        send_record(text_chars("03/01/2100 12:00:00 PM"));
        send_record(text_chars("03/01/1900 01:00:00 AM"));
        send_record(text_chars("12/31/1990 12:30:45 am"));
        send_record(text_chars("00/00/0000 00:00:00 XM"));
        send_record(text_chars("99/99/9999 99:99:99 pm"));
        send_record(text_chars("07/04/1991 12:07:08 ?M"));
        send_record(text_chars("07/04/1991 06:07:08 aM~~~"));
        q     = text_chars("01/01/1990 12:00:00 AM");
        q[2]  = 8'hFF;
        q[21] = CH_NUL;
        send_record(q);
        send_record(text_chars("1A/01/2000 01:00:00 AM"));
        send_record(text_chars("01/01/2000 01:00:0: AM"));
        send_record(text_chars("01/02/2000"));
        send_record(text_chars("01/02/2000 01:00:00 A"));
        send_record(text_chars("5"));
        q = '{CH_NUL};
        send_record(q);
        q    = text_chars("x1/01/2000 01:00:00 PM");
        q[0] = CH_NUL;
        send_record(q);

        // Random records, mostly well formed
        start_chars = chars_sent;
        while (chars_sent < start_chars + RANDOM_CHARS) begin
            calm = (chars_sent >= start_chars + RANDOM_CHARS - CALM_CHARS);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                q = random_stamp();
            end else if (kind < 80) begin
                // Put a non-digit into a digit position
                q = random_stamp();
                q[DIGIT_POS[$urandom_range(0, 13)]] = pick_non_digit();
            end else if (kind < 90) begin
                // End the record early
                q   = random_stamp();
                cut = $urandom_range(1, 21);
                while (q.size() > cut) void'(q.pop_back());
            end else if (kind < 95) begin
                // Start with NUL, anything after
                q = '{CH_NUL};
                n = $urandom_range(0, 26);
                repeat (n) q.push_back(8'($urandom_range(0, 255)));
            end else begin
                q = {};
                n = $urandom_range(1, 30);
                repeat (n) q.push_back(8'($urandom_range(0, 255)));
            end
            send_record(q);
        end
        calm = 1'b1;
        @(negedge clk);
        push <= 1'b0;

        // Wait for the last results, then let the pipeline settle
        drain = 0;
        while (sb.pending.size() != 0 && drain < DRAIN_CYCLES) begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.pending.size() != 0)
            $display("%0d expected results never arrived", sb.pending.size());
        $display("Sent %0d characters in %0d records; checked %0d results.",
                 chars_sent, sb.records_seen, sb.results_seen);
        $display("Of those records %0d were flagged bad and %0d were empty; %0d mismatches.",
                 sb.records_bad, sb.records_empty, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
